// ----- hdl/lpht_pkg.sv -----
// Package for the linear probing hash table.
// Holds the request and response beat types, opcodes and sequencer states.
// No dependencies.
`default_nettype none

package lpht_pkg;

  localparam int KEY_W        = 60;
  localparam int SLOT_INDEX_W = 10;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_DONE
  } state_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [KEY_W-1:0]   key;
  } req_t;

  typedef struct packed {
    logic [KEY_W-1:0]        stored_value;
    logic                    slot_empty;
    logic [SLOT_INDEX_W-1:0] slot_index;
    logic                    table_full;
  } rsp_t;

endpackage

`default_nettype wire

// ----- hdl/linear_probing_hash_table.sv -----
// Top level of the linear probing hash table with its probe sequencer.
// Depends on lpht_pkg and lpht_ram.
// TABLE_SIZE must be a power of two; the home slot is the low bits of the key.
`default_nettype none

// After reset the block runs a clearing pass over the occupancy bitmap, one
// 64-slot word per cycle, and holds req_stall high until it is done. A lookup
// reads the bitmap and key store at accept, checks the home slot in S_CHECK
// and passes its result from res to the output register in S_DONE. An insert
// scans bitmap words in turn from its home word, wrapping round; the scan
// is set by the single read port of the bitmap memory feeding one shared
// 64-bit free-slot finder. An insert into a full table skips the scan and
// goes straight to S_DONE. A finished result waits in the output register
// while the next request is taken.
module linear_probing_hash_table #(
  parameter int TABLE_SIZE = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire lpht_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output lpht_pkg::rsp_t     rsp
);

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int WORD_W = (TABLE_SIZE < 64) ? TABLE_SIZE : 64;
  localparam int OFF_W  = $clog2(WORD_W);
  localparam int ROWS   = TABLE_SIZE / WORD_W;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W  = IDX_W + 1;
  localparam int KEY_W  = lpht_pkg::KEY_W;
  localparam int SIX_W  = lpht_pkg::SLOT_INDEX_W;

  lpht_pkg::state_t  state, state_next;
  lpht_pkg::opcode_t op, op_next;
  logic [KEY_W-1:0]  key, key_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [OFF_W-1:0]  offset, offset_next;
  logic              first, first_next;
  logic [CNT_W-1:0]  count, count_next;
  lpht_pkg::rsp_t    res, res_next;
  lpht_pkg::rsp_t    rsp_next;
  logic              rsp_valid_next;

  logic              occ_we;
  logic [ROW_W-1:0]  occ_waddr, occ_raddr;
  logic [WORD_W-1:0] occ_wdata, occ_rdata;
  logic              val_we;
  logic [IDX_W-1:0]  val_waddr, val_raddr;
  logic [KEY_W-1:0]  val_rdata;

  logic [IDX_W-1:0]  home_req, home, pos;
  logic [ROW_W-1:0]  row_req, row_inc;
  logic [WORD_W-1:0] free_bits, onehot;
  logic [OFF_W-1:0]  enc;
  logic              found, occ_bit;

  lpht_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (occ_raddr),
    .rdata (occ_rdata)
  );

  lpht_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SIZE)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (key),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  // Free-slot finder over one bitmap word, shared by every probe step.
  always_comb begin
    free_bits = ~occ_rdata & (first ? ({WORD_W{1'b1}} << offset) : {WORD_W{1'b1}});
    onehot    = free_bits & (~free_bits + 1'b1);
    found     = |free_bits;
    enc       = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (onehot[i]) begin
        enc = enc | OFF_W'(i);
      end
    end
  end

  assign home_req = req.key[IDX_W-1:0];
  assign home     = key[IDX_W-1:0];
  assign row_req  = ROW_W'(home_req >> OFF_W);
  assign row_inc  = (row == ROW_W'(ROWS - 1)) ? '0 : row + 1'b1;
  assign pos      = IDX_W'({row, enc});
  assign occ_bit  = occ_rdata[offset];

  always_comb begin
    state_next     = state;
    op_next        = op;
    key_next       = key;
    row_next       = row;
    offset_next    = offset;
    first_next     = first;
    count_next     = count;
    res_next       = res;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    req_stall      = 1'b1;
    occ_we         = 1'b0;
    occ_waddr      = row;
    occ_wdata      = occ_rdata | onehot;
    occ_raddr      = row;
    val_we         = 1'b0;
    val_waddr      = pos;
    val_raddr      = home;

    unique case (state)
      lpht_pkg::S_CLEAR: begin
        occ_we    = 1'b1;
        occ_wdata = '0;
        row_next  = row_inc;
        if (row == ROW_W'(ROWS - 1)) begin
          state_next = lpht_pkg::S_IDLE;
        end
      end
      lpht_pkg::S_IDLE: begin
        req_stall = 1'b0;
        occ_raddr = row_req;
        val_raddr = home_req;
        if (req_valid) begin
          op_next     = req.opcode;
          key_next    = req.key;
          row_next    = row_req;
          offset_next = home_req[OFF_W-1:0];
          first_next  = 1'b1;
          if (req.opcode == lpht_pkg::OP_INSERT && count == CNT_W'(TABLE_SIZE)) begin
            res_next.stored_value = '0;
            res_next.slot_empty   = 1'b0;
            res_next.slot_index   = SIX_W'(home_req);
            res_next.table_full   = 1'b1;
            state_next            = lpht_pkg::S_DONE;
          end else begin
            state_next = lpht_pkg::S_CHECK;
          end
        end
      end
      lpht_pkg::S_CHECK: begin
        if (op == lpht_pkg::OP_LOOKUP) begin
          res_next.stored_value = occ_bit ? val_rdata : '0;
          res_next.slot_empty   = ~occ_bit;
          res_next.slot_index   = SIX_W'(home);
          res_next.table_full   = 1'b0;
          state_next            = lpht_pkg::S_DONE;
        end else if (found) begin
          occ_we                = 1'b1;
          val_we                = 1'b1;
          count_next            = count + 1'b1;
          res_next.stored_value = key;
          res_next.slot_empty   = 1'b0;
          res_next.slot_index   = SIX_W'(pos);
          res_next.table_full   = 1'b0;
          state_next            = lpht_pkg::S_DONE;
        end else begin
          row_next   = row_inc;
          occ_raddr  = row_inc;
          first_next = 1'b0;
        end
      end
      lpht_pkg::S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_next       = res;
          rsp_valid_next = 1'b1;
          state_next     = lpht_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lpht_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lpht_pkg::S_CLEAR;
      row       <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      row       <= row_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
    op     <= op_next;
    key    <= key_next;
    offset <= offset_next;
    first  <= first_next;
    res    <= res_next;
    rsp    <= rsp_next;
  end

endmodule

`default_nettype wire

// ----- hdl/lpht_ram.sv -----
// Generic simple dual-port RAM: one write port and one registered read port.
// Used for the key store and the occupancy bitmap; no dependencies.
`default_nettype none

module lpht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
